>>> src/rgbds_pkg.sv
// Package for the 2x2 box downsampler: sizes, register indexes and the pair-sum type.
// Depends on nothing; imported by rgb_2x2_box_downsample.
`timescale 1ns / 1ps
`default_nettype none
package rgbds_pkg;

	localparam int MAX_WIDTH    = 4096;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int LINE_DEPTH   = MAX_WIDTH / 2;
	localparam int SLOT_W       = $clog2(LINE_DEPTH);
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int CFG_W        = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CHAN_W       = 8;
	localparam int PAIR_W       = CHAN_W + 1;
	localparam int QUAD_W       = CHAN_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_HEIGHT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
	localparam logic [CFG_W-1:0] DIM_MIN      = CFG_W'(2);
	localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] HEIGHT_MAX   = CFG_W'(HEIGHT_LIMIT);

	typedef struct packed {
		logic [PAIR_W-1:0] red;
		logic [PAIR_W-1:0] green;
		logic [PAIR_W-1:0] blue;
	} pair_sum_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		r = v;
		if (v < DIM_MIN) r = DIM_MIN;
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/rgb_2x2_box_downsample.sv
// RGB888 2x2 box downsampler: line buffer of pair sums and a rounding output stage.
// Depends on rgbds_pkg.
// Path: accepting the completing pixel loads stage 1; the output register takes it
// when not stalled (two register stages: pair/line read, then rounding).
// Throughput: one pixel per cycle while in_stall is low; the line buffer has one
// write and one read port, and a row uses only one of them, so nothing contends.
// Reset: arst_n clears counters, valids and the left-pixel sum, and sets the
// dimensions to 640 x 480. The line buffer is not cleared; odd rows read only
// what the even row above wrote.
`timescale 1ns / 1ps
`default_nettype none
module rgb_2x2_box_downsample
	import rgbds_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [CHAN_W-1:0]    red_in,
	input  wire logic [CHAN_W-1:0]    green_in,
	input  wire logic [CHAN_W-1:0]    blue_in,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [CHAN_W-1:0]         red_out,
	output logic [CHAN_W-1:0]         green_out,
	output logic [CHAN_W-1:0]         blue_out,
	output logic                      frame_end
);

	logic [CFG_W-1:0] width_q, height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	pair_sum_t        left_q;

	pair_sum_t        line_mem [LINE_DEPTH];
	pair_sum_t        above_s1;
	pair_sum_t        pair_s1;
	logic             valid_s1;
	logic             last_s1;
	logic             out_valid_q;

	logic             cfg_wr, accept, load_out;
	logic [CFG_W-1:0] used_w, used_h, col_ext, row_ext;
	logic             active, odd_col, odd_row, col_wrap, row_wrap, is_last;
	logic [SLOT_W-1:0] slot;
	pair_sum_t        pixel, pair;
	logic [QUAD_W-1:0] sum_r, sum_g, sum_b;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	assign load_out  = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 & !load_out;
	assign accept    = in_valid & !in_stall;

	always_comb begin
		used_w   = {width_q[CFG_W-1:1], 1'b0};
		used_h   = {height_q[CFG_W-1:1], 1'b0};
		col_ext  = CFG_W'(col_q);
		row_ext  = CFG_W'(row_q);
		active   = (col_ext < used_w) && (row_ext < used_h);
		odd_col  = col_q[0];
		odd_row  = row_q[0];
		col_wrap = (col_ext + CFG_W'(1)) >= width_q;
		row_wrap = (row_ext + CFG_W'(1)) >= height_q;
		is_last  = (row_ext == used_h - CFG_W'(1)) && (col_ext == used_w - CFG_W'(1));
		slot     = col_q[COL_W-1:1];
		pixel    = '{red: PAIR_W'(red_in), green: PAIR_W'(green_in), blue: PAIR_W'(blue_in)};
		pair.red   = left_q.red + pixel.red;
		pair.green = left_q.green + pixel.green;
		pair.blue  = left_q.blue + pixel.blue;
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_INPUT_WIDTH: begin
					width_q <= clamp_dim(cfg_data, WIDTH_MAX);
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_INPUT_HEIGHT: begin
					height_q <= clamp_dim(cfg_data, HEIGHT_MAX);
					col_q    <= '0;
					row_q    <= '0;
				end
				default: ;
			endcase
		end else if (accept) begin
			if (active && !odd_col) left_q <= pixel;
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line buffer: even rows write pair sums, odd rows read them back
	always_ff @(posedge clk) begin
		if (accept && active && odd_col && !odd_row) line_mem[slot] <= pair;
	end

	always_ff @(posedge clk) begin
		if (accept && active && odd_col && odd_row) begin
			above_s1 <= line_mem[slot];
			pair_s1  <= pair;
			last_s1  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && active && odd_col && odd_row) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		sum_r = QUAD_W'(above_s1.red) + QUAD_W'(pair_s1.red) + QUAD_W'(2);
		sum_g = QUAD_W'(above_s1.green) + QUAD_W'(pair_s1.green) + QUAD_W'(2);
		sum_b = QUAD_W'(above_s1.blue) + QUAD_W'(pair_s1.blue) + QUAD_W'(2);
	end

	// output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && valid_s1) begin
			red_out   <= sum_r[QUAD_W-1:2];
			green_out <= sum_g[QUAD_W-1:2];
			blue_out  <= sum_b[QUAD_W-1:2];
			frame_end <= last_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
